/* hw/rtl/lgr_pkg.sv */
// ----------------------------------------------------------------------------
// lgr_pkg: shared types and constants for the life automaton grid
// Board geometry, rule counts, command and register codes, ring control.
// ----------------------------------------------------------------------------
package lgr_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // width of the board size registers (holds 0..127)
    localparam int DIM_W     = 7;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int COUNT_W   = 4;

    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(10);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(10);

    typedef logic [MAX_WIDTH-1:0] row_word_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_EVOLVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BOARD_WIDTH  = 2'd0,
        REG_BOARD_HEIGHT = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_EVOLVE,
        ST_FINISH
    } state_t;

    // control broadcast to every row cell of the ring
    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctl_t;

endpackage

/* hw/rtl/lgr_cell.sv */
// ----------------------------------------------------------------------------
// lgr_cell: one row cell of the board ring
// Holds one row word; takes the word of its neighbor on a shift, drops it on clear.
// ----------------------------------------------------------------------------
module lgr_cell
    import lgr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ring_ctl_t ctl,
    input  row_word_t d_in,
    output row_word_t q
);

    row_word_t row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            row_reg <= '0;
        end else if (ctl.shift) begin
            row_reg <= d_in;
        end
    end

    assign q = row_reg;

endmodule

/* hw/rtl/lgr_rule.sv */
// ----------------------------------------------------------------------------
// lgr_rule: next generation of one row under rule B3/S23
// Counts the eight neighbors of every column lane from three row words.
// ----------------------------------------------------------------------------
module lgr_rule
    import lgr_pkg::*;
(
    input  row_word_t prev_row,
    input  row_word_t cur_row,
    input  row_word_t next_row,
    input  row_word_t col_mask,
    output row_word_t new_row
);

    row_word_t p_m, c_m, n_m;

    always_comb begin
        logic [COUNT_W-1:0] cnt;
        p_m = prev_row & col_mask;
        c_m = cur_row  & col_mask;
        n_m = next_row & col_mask;
        new_row = cur_row;
        for (int x = 0; x < MAX_WIDTH; x++) begin
            cnt = COUNT_W'(p_m[x]) + COUNT_W'(n_m[x]);
            if (x > 0) begin
                cnt = cnt + COUNT_W'(p_m[x-1]) + COUNT_W'(c_m[x-1]) + COUNT_W'(n_m[x-1]);
            end
            if (x < MAX_WIDTH - 1) begin
                cnt = cnt + COUNT_W'(p_m[x+1]) + COUNT_W'(c_m[x+1]) + COUNT_W'(n_m[x+1]);
            end
            // columns beyond the board keep their value
            if (col_mask[x]) begin
                new_row[x] = (cnt == BIRTH_COUNT) || (cur_row[x] && cnt == SURVIVE_COUNT);
            end
        end
    end

endmodule

/* hw/rtl/life_automaton_grid.sv */
// ----------------------------------------------------------------------------
// life_automaton_grid: Conway life board, rule B3/S23, with command stream
// Board rows live in a ring of row cells that rotates toward the head.
// ----------------------------------------------------------------------------
// Operation: clear and out-of-board write/read go straight to the finish
//   state; in-board write/read rotate the ring until the addressed row reaches
//   the head cell; evolve aligns to row 0, then makes one full rotation, one
//   row per cycle.
// Flow: one transaction at a time; the next is taken once the current one
//   has its result in the output register.
// Reset: synchronous on aresetn low; all cells dead, width and height 10.
// ----------------------------------------------------------------------------
module life_automaton_grid
    import lgr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write port
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_wdata,
    // command stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // command[1:0], col_x[7:2], row_y[13:8], alive_in[14]
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata    // alive_out[0], out_of_range[1]
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BOARD_WIDTH:  width_reg  <= cfg_wdata;
                REG_BOARD_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturate the registers into the board in use: zero acts as one
    logic [DIM_W-1:0] w_eff, h_eff;
    row_word_t        col_mask;

    always_comb begin
        w_eff = width_reg;
        if (w_eff == '0)                      w_eff = DIM_W'(1);
        if (w_eff > DIM_W'(MAX_WIDTH))        w_eff = DIM_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (h_eff == '0)                      h_eff = DIM_W'(1);
        if (h_eff > DIM_W'(MAX_HEIGHT))       h_eff = DIM_W'(MAX_HEIGHT);
        for (int x = 0; x < MAX_WIDTH; x++) begin
            col_mask[x] = DIM_W'(x) < w_eff;
        end
    end

    // ------------------------------------------------------------------
    // command fields
    // ------------------------------------------------------------------
    cmd_t             in_cmd;
    logic [COL_W-1:0] in_x;
    logic [ROW_W-1:0] in_y;
    logic             in_v;

    assign in_cmd = cmd_t'(s_tdata[1:0]);
    assign in_x   = s_tdata[7:2];
    assign in_y   = s_tdata[13:8];
    assign in_v   = s_tdata[14];

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] target_reg, target_next;
    logic             v_reg, v_next;
    logic [ROW_W-1:0] head_reg, head_next;     // board row held by the head cell
    row_word_t        prev_reg, prev_next;     // old copy of the row above the head
    logic             res_alive_reg, res_alive_next;
    logic             res_oor_reg, res_oor_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_data_reg, m_data_next;

    // ring of row cells; cell 0 is the head, the head word re-enters at the tail
    row_word_t        row_q [MAX_HEIGHT];
    row_word_t        tail_word;
    ring_ctl_t        ring_ctl;
    row_word_t        rule_out;
    row_word_t        rule_prev, rule_next;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HEIGHT; gi++) begin : g_ring
            row_word_t cell_d;
            if (gi == MAX_HEIGHT - 1) begin : g_tail
                assign cell_d = tail_word;
            end else begin : g_link
                assign cell_d = row_q[gi+1];
            end
            lgr_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ring_ctl),
                .d_in    (cell_d),
                .q       (row_q[gi])
            );
        end
    endgenerate

    // neighbor rows for the head; rows outside the board read as dead
    logic head_in_board;

    always_comb begin
        head_in_board = DIM_W'(head_reg) < h_eff;
        rule_prev = (head_reg != '0) ? prev_reg : '0;
        rule_next = ((DIM_W'(head_reg) + DIM_W'(1)) < h_eff) ? row_q[1] : '0;
    end

    lgr_rule u_rule (
        .prev_row (rule_prev),
        .cur_row  (row_q[0]),
        .next_row (rule_next),
        .col_mask (col_mask),
        .new_row  (rule_out)
    );

    logic in_inside;
    assign in_inside = (DIM_W'(in_x) < w_eff) && (DIM_W'(in_y) < h_eff);

    always_comb begin
        row_word_t patched;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        target_next    = target_reg;
        v_next         = v_reg;
        head_next      = head_reg;
        prev_next      = prev_reg;
        res_alive_next = res_alive_reg;
        res_oor_next   = res_oor_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ring_ctl       = '0;
        tail_word      = row_q[0];
        s_tready       = 1'b0;
        patched        = row_q[0];
        patched[x_reg] = v_reg;

        // drop the result once the consumer takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next       = in_cmd;
                    x_next         = in_x;
                    v_next         = in_v;
                    res_alive_next = 1'b0;
                    res_oor_next   = 1'b0;
                    case (in_cmd)
                        CMD_WRITE, CMD_READ: begin
                            target_next = in_y;
                            if (in_inside) begin
                                state_next = ST_SEEK;
                            end else begin
                                res_oor_next = 1'b1;
                                state_next   = ST_FINISH;
                            end
                        end
                        CMD_EVOLVE: begin
                            target_next = '0;
                            state_next  = ST_SEEK;
                        end
                        CMD_CLEAR: begin
                            ring_ctl.clear = 1'b1;
                            state_next     = ST_FINISH;
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end

            ST_SEEK: begin
                if (head_reg == target_reg) begin
                    case (cmd_reg)
                        CMD_WRITE: begin
                            // patch the head word as it passes to the tail
                            ring_ctl.shift = 1'b1;
                            tail_word      = patched;
                            head_next      = (head_reg == ROW_W'(MAX_HEIGHT - 1)) ?
                                             '0 : head_reg + ROW_W'(1);
                            state_next     = ST_FINISH;
                        end
                        CMD_READ: begin
                            res_alive_next = row_q[0][x_reg];
                            state_next     = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_EVOLVE;
                        end
                    endcase
                end else begin
                    ring_ctl.shift = 1'b1;
                    head_next      = (head_reg == ROW_W'(MAX_HEIGHT - 1)) ?
                                     '0 : head_reg + ROW_W'(1);
                end
            end

            ST_EVOLVE: begin
                // one row per cycle; rows below the board pass unchanged
                ring_ctl.shift = 1'b1;
                tail_word      = head_in_board ? rule_out : row_q[0];
                prev_next      = row_q[0];
                if (head_reg == ROW_W'(MAX_HEIGHT - 1)) begin
                    head_next  = '0;
                    state_next = ST_FINISH;
                end else begin
                    head_next  = head_reg + ROW_W'(1);
                end
            end

            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_oor_reg, res_alive_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        target_reg    <= target_next;
        v_reg         <= v_next;
        prev_reg      <= prev_next;
        res_alive_reg <= res_alive_next;
        res_oor_reg   <= res_oor_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

endmodule

/* tb/tb_life_automaton_grid.sv */
// ----------------------------------------------------------------------------
// tb_life_automaton_grid: self-checking bench for the B3/S23 life grid
// Drives write, read, clear and evolve commands through the command stream,
// mirrors every board change in a software copy of the grid, and compares
// each result transaction with the copy's answer, under random idling.
// ----------------------------------------------------------------------------
module tb_life_automaton_grid;
    import lgr_pkg::*;

    // Guard on run length: worst item is a full evolve plus a long stall on
    // both sides, over roughly 1250 items, then taken about five times over.
    localparam int CYCLE_LIMIT    = 2_000_000;
    // Evolve aligns to row 0 and then rotates the whole ring once.
    localparam int SETTLE_CYCLES  = 2 * MAX_HEIGHT + 4;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_OFF_LEN   = 300;
    // Register index past the end of the register map; the block ignores it.
    localparam logic [1:0] UNUSED_REG_INDEX = 2'd3;

    typedef struct packed {
        logic alive;
        logic out_of_range;
    } cell_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [DIM_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;   // command[1:0], col_x[7:2], row_y[13:8], alive_in[14]
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // alive_out[0], out_of_range[1]

    // Software copy of the grid and its size registers.
    row_word_t        life_board [MAX_HEIGHT];
    logic [DIM_W-1:0] board_width_q;
    logic [DIM_W-1:0] board_height_q;

    cell_result_t     pending_results [$];

    int  n_errors;
    int  n_items;
    int  n_results;
    int  n_evolves;
    int  n_off_board;
    int  cycle_count;
    int  hold_off_request;
    bit  steady;

    life_automaton_grid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Grid predictor
    // ------------------------------------------------------------------

    // Size in use: a register value of 0 acts as 1, anything past the
    // built-in maximum saturates to it.
    function automatic int used_span(input logic [DIM_W-1:0] reg_val, input int limit);
        if (reg_val == '0)
            return 1;
        if (int'(reg_val) > limit)
            return limit;
        return int'(reg_val);
    endfunction

    // One B3/S23 generation over the board in use, from a snapshot. Cells
    // past the board keep their value and never count as neighbors.
    function automatic void advance_generation(input int w, input int h);
        row_word_t next_gen [MAX_HEIGHT];
        int        row, col, dy, dx, nrow, ncol, count;
        logic      was_alive;
        for (row = 0; row < h; row++) begin
            next_gen[row] = life_board[row];
            for (col = 0; col < w; col++) begin
                count = 0;
                for (dy = -1; dy <= 1; dy++) begin
                    for (dx = -1; dx <= 1; dx++) begin
                        nrow = row + dy;
                        ncol = col + dx;
                        if ((dy != 0 || dx != 0) && nrow >= 0 && ncol >= 0 &&
                            nrow < h && ncol < w)
                            count += int'(life_board[nrow][ncol]);
                    end
                end
                was_alive = life_board[row][col];
                next_gen[row][col] = was_alive ?
                    (count == int'(SURVIVE_COUNT) || count == int'(BIRTH_COUNT)) :
                    (count == int'(BIRTH_COUNT));
            end
        end
        for (row = 0; row < h; row++)
            life_board[row] = next_gen[row];
    endfunction

    // Apply one command to the copy and return the result it should give.
    function automatic cell_result_t life_predict(input cmd_t cmd,
                                                  input logic [COL_W-1:0] x,
                                                  input logic [ROW_W-1:0] y,
                                                  input logic v);
        cell_result_t res;
        int           w, h, row;
        logic         on_board;
        res      = '0;
        w        = used_span(board_width_q, MAX_WIDTH);
        h        = used_span(board_height_q, MAX_HEIGHT);
        on_board = (int'(x) < w) && (int'(y) < h);
        case (cmd)
            CMD_WRITE: begin
                if (on_board)
                    life_board[y][x] = v;
                else
                    res.out_of_range = 1'b1;
            end
            CMD_EVOLVE: begin
                advance_generation(w, h);
            end
            CMD_READ: begin
                if (on_board)
                    res.alive = life_board[y][x];
                else
                    res.out_of_range = 1'b1;
            end
            default: begin
                for (row = 0; row < MAX_HEIGHT; row++)
                    life_board[row] = '0;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Pause length: mostly short, now and then long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Offer one command; record its expected result once the transaction
    // is accepted. Valid stays high between back-to-back commands.
    task automatic send_command(input cmd_t cmd, input logic [COL_W-1:0] x,
                                input logic [ROW_W-1:0] y, input logic v);
        int gap;
        gap = (steady || $urandom_range(0, 99) >= 35) ? 0 : pick_pause();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v, y, x, cmd};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(life_predict(cmd, x, y, v));
        n_items++;
        if (cmd == CMD_EVOLVE)
            n_evolves++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write; callers make sure the block is idle.
    task automatic write_register(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BOARD_WIDTH)
            board_width_q = val;
        else if (idx == REG_BOARD_HEIGHT)
            board_height_q = val;
    endtask

    task automatic set_board(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        write_register(REG_BOARD_WIDTH, w);
        write_register(REG_BOARD_HEIGHT, h);
    endtask

    // Random command aimed mostly inside the board in use, so that patterns
    // actually build up and evolve; the rest hits anywhere on the address space.
    task automatic send_random_item();
        int         w, h, r;
        cmd_t       cmd;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        w = used_span(board_width_q, MAX_WIDTH);
        h = used_span(board_height_q, MAX_HEIGHT);
        r = $urandom_range(0, 99);
        if (r < 46)
            cmd = CMD_WRITE;
        else if (r < 82)
            cmd = CMD_READ;
        else if (r < 97)
            cmd = CMD_EVOLVE;
        else
            cmd = CMD_CLEAR;
        if ($urandom_range(0, 99) < 88) begin
            x = COL_W'($urandom_range(0, w - 1));
            y = ROW_W'($urandom_range(0, h - 1));
        end else begin
            x = COL_W'($urandom_range(0, MAX_WIDTH - 1));
            y = ROW_W'($urandom_range(0, MAX_HEIGHT - 1));
        end
        send_command(cmd, x, y, $urandom_range(0, 99) < 55);
    endtask

    // Board size for a random phase: mostly small, with the extremes and
    // out-of-range register values mixed in.
    function automatic logic [DIM_W-1:0] pick_dimension();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return DIM_W'($urandom_range(MAX_WIDTH + 1, 127));
        if (r < 32)
            return DIM_W'(MAX_WIDTH);
        if (r < 40)
            return DIM_W'(1);
        return DIM_W'($urandom_range(2, 16));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset board is 10x10 and dead; poke its edges and far outside it.
    task automatic test_power_on_board();
        send_command(CMD_READ, 6'd9, 6'd9, 1'b0);
        send_command(CMD_READ, 6'd10, 6'd9, 1'b0);
        send_command(CMD_WRITE, 6'd0, 6'd10, 1'b1);
        send_command(CMD_WRITE, 6'd63, 6'd63, 1'b1);
        send_command(CMD_READ, 6'd63, 6'd63, 1'b0);
    endtask

    // Zero acts as one, anything above the maximum saturates, and a write
    // to an index past the register map changes nothing.
    task automatic test_register_limits();
        set_board(DIM_W'(0), DIM_W'(127));
        send_command(CMD_WRITE, 6'd0, 6'd63, 1'b1);
        send_command(CMD_READ, 6'd1, 6'd0, 1'b0);
        send_command(CMD_READ, 6'd0, 6'd63, 1'b0);
        set_board(DIM_W'(127), DIM_W'(0));
        write_register(UNUSED_REG_INDEX, DIM_W'(127));
        send_command(CMD_WRITE, 6'd63, 6'd0, 1'b1);
        send_command(CMD_READ, 6'd63, 6'd0, 1'b0);
        send_command(CMD_READ, 6'd0, 6'd1, 1'b0);
    endtask

    // Plant a blinker just past the right edge of a 5x5 board and a lone
    // cell further out. Evolve on the small board must neither see them as
    // neighbors nor touch them.
    task automatic test_edge_isolation();
        set_board(DIM_W'(10), DIM_W'(10));
        send_command(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
        send_command(CMD_WRITE, 6'd5, 6'd1, 1'b1);
        send_command(CMD_WRITE, 6'd5, 6'd2, 1'b1);
        send_command(CMD_WRITE, 6'd5, 6'd3, 1'b1);
        send_command(CMD_WRITE, 6'd8, 6'd8, 1'b1);
        set_board(DIM_W'(5), DIM_W'(5));
        send_command(CMD_EVOLVE, 6'd0, 6'd0, 1'b0);
        set_board(DIM_W'(10), DIM_W'(10));
        send_command(CMD_READ, 6'd4, 6'd2, 1'b0);
        send_command(CMD_READ, 6'd8, 6'd8, 1'b0);
        send_command(CMD_READ, 6'd5, 6'd2, 1'b0);
    endtask

    // Clear on a tiny board still kills cells outside it.
    task automatic test_clear_beyond_board();
        set_board(DIM_W'(3), DIM_W'(3));
        send_command(CMD_CLEAR, 6'd0, 6'd0, 1'b0);
        set_board(DIM_W'(10), DIM_W'(10));
        send_command(CMD_READ, 6'd8, 6'd8, 1'b0);
        send_command(CMD_READ, 6'd5, 6'd2, 1'b0);
    endtask

    // Hold the result side off for a long stretch while commands keep
    // coming, so the block fills and stalls its input; then pause the
    // sender until everything has drained.
    task automatic test_output_backpressure();
        set_board(DIM_W'(8), DIM_W'(8));
        steady           = 1'b1;
        hold_off_request = HOLD_OFF_LEN;
        repeat (10) send_random_item();
        steady = 1'b0;
        wait_idle();
    endtask

    // Phases of random play, each on its own board size; every third phase
    // runs with no idling on either side.
    task automatic test_random_play();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_board(DIM_W'(MAX_WIDTH), DIM_W'(MAX_HEIGHT));
                1:       set_board(DIM_W'(1), DIM_W'(1));
                2:       set_board(DIM_W'(0), DIM_W'(127));
                3:       set_board(DIM_W'(3), DIM_W'(MAX_HEIGHT));
                default: set_board(pick_dimension(), pick_dimension());
            endcase
            steady = (phase % 3 == 2);
            repeat (PHASE_ITEMS) send_random_item();
            steady = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus a requested long hold-off
    // ------------------------------------------------------------------
    initial begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request > 0) begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25) begin
                stall_left = pick_pause();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tdata[1])
                n_off_board++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual alive_out %0b out_of_range %0b",
                         $time, m_tdata[0], m_tdata[1]);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.alive) begin
                    $display("%0t: alive_out mismatch, expected %0b, actual %0b",
                             $time, want.alive, m_tdata[0]);
                    n_errors++;
                end
                if (m_tdata[1] !== want.out_of_range) begin
                    $display("%0t: out_of_range mismatch, expected %0b, actual %0b",
                             $time, want.out_of_range, m_tdata[1]);
                    n_errors++;
                end
            end
        end
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int row;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        n_errors         = 0;
        n_items          = 0;
        n_results        = 0;
        n_evolves        = 0;
        n_off_board      = 0;
        cycle_count      = 0;
        hold_off_request = 0;
        steady           = 1'b0;
        board_width_q    = RESET_WIDTH;
        board_height_q   = RESET_HEIGHT;
        for (row = 0; row < MAX_HEIGHT; row++)
            life_board[row] = '0;

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_on_board();
        test_register_limits();
        test_edge_isolation();
        test_clear_beyond_board();
        test_output_backpressure();
        test_random_play();

        // Drain, then give any stray result time to show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            n_errors++;
        end

        $display("covered %0d commands (%0d evolve generations), %0d results, %0d off-board",
                 n_items, n_evolves, n_results, n_off_board);
        $display("board sizes from 1x1 to 64x64 incl. saturated registers, %0d errors",
                 n_errors);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
